@@ src/bpc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the barometer
// compensation pipeline. No dependencies.
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int unsigned DIV_STAGES = 32;

  localparam logic [7:0] CFG_CAL_A = 8'd0;
  localparam logic [7:0] CFG_CAL_B = 8'd1;
  localparam logic [7:0] CFG_CAL_C = 8'd2;
  localparam logic [7:0] CFG_OSS   = 8'd3;

  localparam logic [31:0] T_OFFSET = 32'd4000;
  localparam logic [31:0] P_C1     = 32'd3038;
  localparam logic [31:0] P_C2     = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_C3     = 32'd3791;
  localparam logic [31:0] B7_SCALE = 32'd50000;
  localparam logic [31:0] B4_BIAS  = 32'd32768;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cal_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] x1;
    logic        neg;
    logic        fault;
    logic        bz;
    logic        hi;
    logic [23:0] up;
  } side_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] num;
    logic [31:0] den;
    side_t       side;
  } div_in_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] quo;
    side_t       side;
  } div_out_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] nq;
    logic [31:0] den;
    side_t       side;
  } div_st_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] f;
    f = 64'(a) * 64'(b);
    return f[31:0];
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] sh);
    return 32'($signed(v) >>> sh);
  endfunction

  // One restoring step: the next numerator bit enters the remainder and one
  // quotient bit leaves at the bottom of nq.
  function automatic div_st_t div_step(input div_st_t s);
    logic [32:0] t;
    logic [32:0] dif;
    div_st_t     r;
    r   = s;
    t   = {s.rem, s.nq[31]};
    dif = t - {1'b0, s.den};
    if (!dif[32]) begin
      r.rem = dif[31:0];
      r.nq  = {s.nq[30:0], 1'b1};
    end else begin
      r.rem = t[31:0];
      r.nq  = {s.nq[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ src/bpc_udiv_pipe.sv @@
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
module bpc_udiv_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  bpc_pkg::div_in_t  req,
  output bpc_pkg::div_out_t rsp
);

  logic [bpc_pkg::DIV_STAGES-1:0] v_r;
  bpc_pkg::div_st_t               st_r [bpc_pkg::DIV_STAGES];
  bpc_pkg::div_st_t               first_nxt;

  always_comb begin
    first_nxt.rem  = '0;
    first_nxt.nq   = req.num;
    first_nxt.den  = req.den;
    first_nxt.side = req.side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[bpc_pkg::DIV_STAGES-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    st_r[0] <= bpc_pkg::div_step(first_nxt);
    for (int k = 1; k < bpc_pkg::DIV_STAGES; k++) begin
      st_r[k] <= bpc_pkg::div_step(st_r[k-1]);
    end
  end

  assign rsp.valid = v_r[bpc_pkg::DIV_STAGES-1];
  assign rsp.quo   = st_r[bpc_pkg::DIV_STAGES-1].nq;
  assign rsp.side  = st_r[bpc_pkg::DIV_STAGES-1].side;

endmodule

@@ src/bpc_temp_pre.sv @@
// Temperature front end: first product, divisor and operand magnitudes for
// the temperature division. Depends on bpc_pkg.
`timescale 1ns / 1ps
module bpc_temp_pre (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [15:0]      ut,
  input  logic [23:0]      praw,
  input  bpc_pkg::cal_t    cal,
  output bpc_pkg::div_in_t req
);

  logic             a_v_r;
  logic [31:0]      a_t1_r;
  logic [23:0]      a_up_r;
  bpc_pkg::div_in_t b_r;

  logic [31:0] x1;
  logic [31:0] d;
  logic [31:0] nm;
  logic [3:0]  psh;

  assign psh = 4'd8 - {2'b00, cal.oss};

  always_comb begin
    x1 = bpc_pkg::asr32(a_t1_r, 5'd15);
    d  = x1 + bpc_pkg::sx16(cal.md);
    nm = bpc_pkg::sx16(cal.mc) << 11;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r     <= 1'b0;
      b_r.valid <= 1'b0;
    end else begin
      a_v_r     <= in_valid;
      b_r.valid <= a_v_r;
    end

    a_t1_r <= bpc_pkg::mul32({16'd0, ut} - {16'd0, cal.ac6}, {16'd0, cal.ac5});
    a_up_r <= praw >> psh;

    b_r.num        <= nm[31] ? (32'd0 - nm) : nm;
    b_r.den        <= d[31] ? (32'd0 - d) : d;
    b_r.side.x1    <= x1;
    b_r.side.neg   <= nm[31] ^ d[31];
    b_r.side.fault <= (d == 32'd0);
    b_r.side.up    <= a_up_r;
    b_r.side.temp  <= '0;
    b_r.side.bz    <= 1'b0;
    b_r.side.hi    <= 1'b0;
  end

  assign req = b_r;

endmodule

@@ src/bpc_press_front.sv @@
// Temperature finish and pressure terms b3, b4 and b7, ending in the request
// for the pressure division. Depends on bpc_pkg.
`timescale 1ns / 1ps
module bpc_press_front (
  input  logic              clk,
  input  logic              rst_n,
  input  bpc_pkg::div_out_t rsp,
  input  bpc_pkg::cal_t     cal,
  output bpc_pkg::div_in_t  req
);

  logic [5:0] v_r;

  // Stage registers, one group per pipeline step.
  logic [31:0]      c_b6_r;
  bpc_pkg::side_t   c_side_r;
  logic [31:0]      d_sqp_r, d_m2_r, d_m3_r;
  bpc_pkg::side_t   d_side_r;
  logic [31:0]      e_sq_r, e_x2a_r, e_x1c_r;
  bpc_pkg::side_t   e_side_r;
  logic [31:0]      f_mb2_r, f_mb1_r, f_x2a_r, f_x1c_r;
  bpc_pkg::side_t   f_side_r;
  logic [31:0]      g_b3_r, g_x3b_r;
  bpc_pkg::side_t   g_side_r;
  logic [31:0]      h_b4p_r, h_b7p_r;
  bpc_pkg::side_t   h_side_r;
  bpc_pkg::div_in_t i_r;

  logic [31:0] q, x2, b5, x3, tmp, v, x3b, b4;
  bpc_pkg::side_t c_side_nxt, i_side_nxt;

  always_comb begin
    q   = rsp.side.neg ? (32'd0 - rsp.quo) : rsp.quo;
    x2  = rsp.side.fault ? 32'd0 : q;
    b5  = rsp.side.x1 + x2;
    x3  = bpc_pkg::asr32(f_mb2_r, 5'd11) + f_x2a_r;
    tmp = ((bpc_pkg::sx16(cal.ac1) << 2) + x3) << cal.oss;
    v   = tmp + 32'd2;
    x3b = bpc_pkg::asr32(f_x1c_r + bpc_pkg::asr32(f_mb1_r, 5'd16) + 32'd2, 5'd2);
    b4  = h_b4p_r >> 15;

    c_side_nxt      = rsp.side;
    c_side_nxt.temp = bpc_pkg::asr32(b5 + 32'd8, 5'd4);

    i_side_nxt    = h_side_r;
    i_side_nxt.hi = h_b7p_r[31];
    i_side_nxt.bz = (b4 == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      i_r.valid <= 1'b0;
    end else begin
      v_r       <= {v_r[4:0], rsp.valid};
      i_r.valid <= v_r[5];
    end

    c_b6_r   <= b5 - bpc_pkg::T_OFFSET;
    c_side_r <= c_side_nxt;

    d_sqp_r  <= bpc_pkg::mul32(c_b6_r, c_b6_r);
    d_m2_r   <= bpc_pkg::mul32(bpc_pkg::sx16(cal.ac2), c_b6_r);
    d_m3_r   <= bpc_pkg::mul32(bpc_pkg::sx16(cal.ac3), c_b6_r);
    d_side_r <= c_side_r;

    e_sq_r   <= bpc_pkg::asr32(d_sqp_r, 5'd12);
    e_x2a_r  <= bpc_pkg::asr32(d_m2_r, 5'd11);
    e_x1c_r  <= bpc_pkg::asr32(d_m3_r, 5'd13);
    e_side_r <= d_side_r;

    f_mb2_r  <= bpc_pkg::mul32(bpc_pkg::sx16(cal.b2), e_sq_r);
    f_mb1_r  <= bpc_pkg::mul32(bpc_pkg::sx16(cal.b1), e_sq_r);
    f_x2a_r  <= e_x2a_r;
    f_x1c_r  <= e_x1c_r;
    f_side_r <= e_side_r;

    // Division by four that truncates towards zero.
    g_b3_r   <= bpc_pkg::asr32(v + (v[31] ? 32'd3 : 32'd0), 5'd2);
    g_x3b_r  <= x3b;
    g_side_r <= f_side_r;

    h_b4p_r  <= bpc_pkg::mul32({16'd0, cal.ac4}, g_x3b_r + bpc_pkg::B4_BIAS);
    h_b7p_r  <= bpc_pkg::mul32({8'd0, g_side_r.up} - g_b3_r, bpc_pkg::B7_SCALE >> cal.oss);
    h_side_r <= g_side_r;

    // Large b7 is divided first and doubled afterwards to keep the top bit.
    i_r.num  <= h_b7p_r[31] ? h_b7p_r : (h_b7p_r << 1);
    i_r.den  <= b4;
    i_r.side <= i_side_nxt;
  end

  assign req = i_r;

endmodule

@@ src/bpc_press_back.sv @@
// Pressure finish: quotient fix-up, the final polynomial correction and the
// output registers. Depends on bpc_pkg.
`timescale 1ns / 1ps
module bpc_press_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bpc_pkg::div_out_t rsp,
  output logic              out_valid,
  output logic [31:0]       out_temperature,
  output logic [31:0]       out_pressure,
  output logic              out_divide_fault
);

  logic [2:0]  v_r;
  logic [31:0] j_p_r, j_temp_r;
  logic        j_fault_r;
  logic [31:0] k_pm_r, k_m7_r, k_p_r, k_temp_r;
  logic        k_fault_r;
  logic [31:0] l_m3_r, l_x2_r, l_p_r, l_temp_r;
  logic        l_fault_r;
  logic        o_v_r;
  logic [31:0] o_temp_r, o_press_r;
  logic        o_fault_r;

  logic [31:0] p_nxt, ps;

  always_comb begin
    if (rsp.side.bz) begin
      p_nxt = 32'd0;
    end else if (rsp.side.hi) begin
      p_nxt = rsp.quo << 1;
    end else begin
      p_nxt = rsp.quo;
    end
    ps = bpc_pkg::asr32(j_p_r, 5'd8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      o_v_r <= 1'b0;
    end else begin
      v_r   <= {v_r[1:0], rsp.valid};
      o_v_r <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    j_p_r     <= p_nxt;
    j_temp_r  <= rsp.side.temp;
    j_fault_r <= rsp.side.fault | rsp.side.bz;

    k_pm_r    <= bpc_pkg::mul32(ps, ps);
    k_m7_r    <= bpc_pkg::mul32(bpc_pkg::P_C2, j_p_r);
    k_p_r     <= j_p_r;
    k_temp_r  <= j_temp_r;
    k_fault_r <= j_fault_r;

    l_m3_r    <= bpc_pkg::mul32(k_pm_r, bpc_pkg::P_C1);
    l_x2_r    <= bpc_pkg::asr32(k_m7_r, 5'd16);
    l_p_r     <= k_p_r;
    l_temp_r  <= k_temp_r;
    l_fault_r <= k_fault_r;

    o_press_r <= l_p_r + bpc_pkg::asr32(bpc_pkg::asr32(l_m3_r, 5'd16) + l_x2_r
                                        + bpc_pkg::P_C3, 5'd4);
    o_temp_r  <= l_temp_r;
    o_fault_r <= l_fault_r;
  end

  assign out_valid        = o_v_r;
  assign out_temperature  = o_temp_r;
  assign out_pressure     = o_press_r;
  assign out_divide_fault = o_fault_r;

endmodule

@@ src/baro_pressure_temp_compensation.sv @@
// Top level of the barometer compensation block: configuration registers and
// the pipeline chain. Depends on bpc_pkg and all bpc_ modules.
`timescale 1ns / 1ps
// A reading pair is taken in every clock cycle (busy is always low) and its
// compensated temperature, pressure and fault flag appear on the out_ ports
// for one cycle, marked by out_valid, after the front end, both 32-stage
// dividers (one quotient bit per stage), the pressure stages between them
// and the back end. Results must be taken when shown; there is no back
// pressure. Calibration is to be written only while no reading is in flight.
module baro_pressure_temp_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_raw_temperature,
  input  logic [23:0]        in_raw_pressure_bytes,
  output logic               out_valid,
  output logic signed [31:0] out_temperature,
  output logic signed [31:0] out_pressure,
  output logic               out_divide_fault,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  logic [63:0] cal_a_r, cal_b_r;
  logic [31:0] cal_c_r;
  logic [1:0]  oss_r;

  bpc_pkg::cal_t     cal;
  bpc_pkg::div_in_t  treq, preq;
  bpc_pkg::div_out_t trsp, prsp;
  logic [31:0]       temp_w, press_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
      oss_r   <= 2'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::CFG_CAL_A: cal_a_r <= cfg_wdata;
        bpc_pkg::CFG_CAL_B: cal_b_r <= cfg_wdata;
        bpc_pkg::CFG_CAL_C: cal_c_r <= cfg_wdata[31:0];
        bpc_pkg::CFG_OSS:   oss_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.ac1 = cal_a_r[63:48];
    cal.ac2 = cal_a_r[47:32];
    cal.ac3 = cal_a_r[31:16];
    cal.ac4 = cal_a_r[15:0];
    cal.ac5 = cal_b_r[63:48];
    cal.ac6 = cal_b_r[47:32];
    cal.b1  = cal_b_r[31:16];
    cal.b2  = cal_b_r[15:0];
    cal.mc  = cal_c_r[31:16];
    cal.md  = cal_c_r[15:0];
    cal.oss = oss_r;
  end

  assign busy = 1'b0;

  bpc_temp_pre u_temp_pre (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .ut       (in_raw_temperature),
    .praw     (in_raw_pressure_bytes),
    .cal      (cal),
    .req      (treq)
  );

  bpc_udiv_pipe u_tdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (treq),
    .rsp   (trsp)
  );

  bpc_press_front u_press_front (
    .clk   (clk),
    .rst_n (rst_n),
    .rsp   (trsp),
    .cal   (cal),
    .req   (preq)
  );

  bpc_udiv_pipe u_pdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (preq),
    .rsp   (prsp)
  );

  bpc_press_back u_press_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp              (prsp),
    .out_valid        (out_valid),
    .out_temperature  (temp_w),
    .out_pressure     (press_w),
    .out_divide_fault (out_divide_fault)
  );

  assign out_temperature = $signed(temp_w);
  assign out_pressure    = $signed(press_w);

endmodule

@@ tb/baro_comp_checker.sv @@
// Checker for the barometer compensation block: mirrors the calibration
// registers, predicts each reading's results and compares them in order.
// Depends on bpc_pkg for the register indexes.
`timescale 1ns / 1ps
module baro_comp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [15:0]        in_raw_temperature,
  input  logic [23:0]        in_raw_pressure_bytes,
  input  logic               out_valid,
  input  logic signed [31:0] out_temperature,
  input  logic signed [31:0] out_pressure,
  input  logic               out_divide_fault,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [63:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic        fault;
  } comp_result_t;

  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  logic [1:0]  oss_setting;
  comp_result_t awaited_results[$];
  int mismatches;

  function automatic logic [31:0] s16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(input logic [31:0] v, input int sh);
    return $signed(v) >>> sh;
  endfunction

  // Truncating signed division on 32-bit patterns; the divisor is nonzero.
  function automatic logic [31:0] trunc_div(input logic [31:0] n, input logic [31:0] d);
    logic [31:0] mn, mdv, q;
    mn  = n[31] ? -n : n;
    mdv = d[31] ? -d : d;
    q   = mn / mdv;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  function automatic comp_result_t compensate(input logic [15:0] ut_raw,
                                              input logic [23:0] up_raw);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, sq, d, scale;
    comp_result_t r;
    ac1 = s16(cal_a[63:48]); ac2 = s16(cal_a[47:32]); ac3 = s16(cal_a[31:16]);
    ac4 = {16'd0, cal_a[15:0]};
    ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
    b1 = s16(cal_b[31:16]); b2 = s16(cal_b[15:0]);
    mc = s16(cal_c[31:16]); md = s16(cal_c[15:0]);
    ut = {16'd0, ut_raw};
    up = {8'd0, up_raw} >> (8 - oss_setting);
    r.fault = 1'b0;
    x1 = sra((ut - ac6) * ac5, 15);
    d = x1 + md;
    if (d == 0) begin
      x2 = 0;
      r.fault = 1'b1;
    end else begin
      x2 = trunc_div(mc << 11, d);
    end
    b5 = x1 + x2;
    r.temp = sra(b5 + 32'd8, 4);
    b6 = b5 - 32'd4000;
    sq = sra(b6 * b6, 12);
    x1 = sra(b2 * sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = trunc_div(((ac1 * 32'd4 + x3) << oss_setting) + 32'd2, 32'd4);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    scale = 32'd50000 >> oss_setting;
    b7 = (up - b3) * scale;
    if (b4 == 0) begin
      p = 0;
      r.fault = 1'b1;
    end else if (!b7[31]) begin
      p = (b7 * 32'd2) / b4;
    end else begin
      p = (b7 / b4) * 32'd2;
    end
    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * 32'd3038, 16);
    x2 = sra(-32'd7357 * p, 16);
    r.press = p + sra(x1 + x2 + 32'd3791, 4);
    return r;
  endfunction

  always @(posedge clk) begin
    comp_result_t exp_r;
    if (!rst_n) begin
      cal_a <= '0;
      cal_b <= '0;
      cal_c <= '0;
      oss_setting <= 2'd3;
      awaited_results.delete();
      fail_count <= 0;
      pending <= 0;
      mismatches = 0;
    end else begin
      if (start && !busy)
        awaited_results.push_back(compensate(in_raw_temperature, in_raw_pressure_bytes));
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: temp %0d press %0d fault %0b",
                     out_temperature, out_pressure, out_divide_fault);
        end else begin
          exp_r = awaited_results.pop_front();
          if (exp_r.temp !== out_temperature || exp_r.press !== out_pressure ||
              exp_r.fault !== out_divide_fault) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       $signed(exp_r.temp), $signed(exp_r.press), exp_r.fault,
                       out_temperature, out_pressure, out_divide_fault);
          end
        end
      end
      fail_count <= mismatches;
      pending <= awaited_results.size();
      if (cfg_we) begin
        case (cfg_index)
          bpc_pkg::CFG_CAL_A: cal_a <= cfg_wdata;
          bpc_pkg::CFG_CAL_B: cal_b <= cfg_wdata;
          bpc_pkg::CFG_CAL_C: cal_c <= cfg_wdata[31:0];
          bpc_pkg::CFG_OSS:   oss_setting <= cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

@@ tb/testbench.sv @@
// Top of the barometer compensation testbench: clock, reset, calibration
// phases and reading stimulus. Depends on bpc_pkg, baro_comp_checker and the block.
`timescale 1ns / 1ps
module testbench;

  localparam int PIPE_DEPTH = 77;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [15:0] in_raw_temperature = '0;
  logic [23:0] in_raw_pressure_bytes = '0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic busy, out_valid, out_divide_fault;
  logic signed [31:0] out_temperature, out_pressure;
  int fail_count, pending;
  int cycles = 0;

  always #1 clk = ~clk;

  baro_pressure_temp_compensation uut (.*);
  baro_comp_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("baro_pressure_temp_compensation test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every reading has come out, then let the pipe drain fully.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Keeps start high across back-to-back transfers; lowers it only on idles.
  task automatic send_reading(input logic [15:0] ut, input logic [23:0] up, input bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 31) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_raw_temperature <= ut;
    in_raw_pressure_bytes <= up;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Calibration near the datasheet example with some random spread.
  function automatic logic [63:0] plausible_a();
    return {16'(408 + $urandom_range(200) - 100), 16'(-72 + $urandom_range(40) - 20),
            16'(-14383 + $urandom_range(2000) - 1000), 16'(32741 + $urandom_range(2000) - 1000)};
  endfunction

  function automatic logic [63:0] plausible_b();
    return {16'(32757 + $urandom_range(1000) - 500), 16'(23153 + $urandom_range(2000) - 1000),
            16'(6190 + $urandom_range(400) - 200), 16'(4 + $urandom_range(8))};
  endfunction

  function automatic logic [31:0] plausible_c();
    return {16'(-8711 + $urandom_range(400) - 200), 16'(2868 + $urandom_range(200) - 100)};
  endfunction

  initial begin
    logic [15:0] ut;
    logic [23:0] up;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration: both divisors zero, so the fault flag is raised.
    send_reading(16'd0, 24'd0, 1'b0);
    send_reading(16'hFFFF, 24'hFFFFFF, 1'b0);
    drain();

    // Datasheet example calibration, oversampling 0 and then 3.
    write_reg(bpc_pkg::CFG_CAL_A, {16'd408, -16'sd72, -16'sd14383, 16'd32741});
    write_reg(bpc_pkg::CFG_CAL_B, {16'd32757, 16'd23153, 16'd6190, 16'd4});
    write_reg(bpc_pkg::CFG_CAL_C, 64'({-16'sd8711, 16'd2868}));
    write_reg(bpc_pkg::CFG_OSS, 64'd0);
    send_reading(16'd27898, 24'h5D2300, 1'b0);
    send_reading(16'd0, 24'd0, 1'b0);
    send_reading(16'hFFFF, 24'hFFFFFF, 1'b0);
    send_reading(16'h5555, 24'hAAAAAA, 1'b0);
    send_reading(16'hAAAA, 24'h555555, 1'b0);
    drain();
    write_reg(8'd7, 64'hFFFF_FFFF_FFFF_FFFF);  // unknown index is ignored
    write_reg(bpc_pkg::CFG_OSS, 64'hFFFF_FFFF_FFFF_FFFF);
    send_reading(16'd27898, 24'h5D2300, 1'b0);
    send_reading(16'hFFFF, 24'hFFFFFF, 1'b0);
    drain();

    // Temperature divisor zero: ut = ac6 makes x1 zero, md zero.
    write_reg(bpc_pkg::CFG_CAL_C, 64'({-16'sd8711, 16'd0}));
    send_reading(16'd23153, 24'h5D2300, 1'b0);
    drain();
    // Extreme calibration words.
    write_reg(bpc_pkg::CFG_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bpc_pkg::CFG_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bpc_pkg::CFG_CAL_C, 64'hFFFF_FFFF);
    send_reading(16'd0, 24'hFFFFFF, 1'b0);
    send_reading(16'hFFFF, 24'd0, 1'b0);
    drain();
    write_reg(bpc_pkg::CFG_CAL_A, 64'h8000_8000_8000_0000);
    write_reg(bpc_pkg::CFG_CAL_B, 64'h8000_0000_7FFF_8000);
    write_reg(bpc_pkg::CFG_CAL_C, 64'h7FFF_8000);
    send_reading(16'h8000, 24'h800000, 1'b0);
    send_reading(16'h7FFF, 24'h7FFFFF, 1'b0);
    drain();

    // Random phases: mostly realistic calibration, some fully random words.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 2) begin
        write_reg(bpc_pkg::CFG_CAL_A, {$urandom, $urandom});
        write_reg(bpc_pkg::CFG_CAL_B, {$urandom, $urandom});
        write_reg(bpc_pkg::CFG_CAL_C, 64'($urandom));
      end else begin
        write_reg(bpc_pkg::CFG_CAL_A, plausible_a());
        write_reg(bpc_pkg::CFG_CAL_B, plausible_b());
        write_reg(bpc_pkg::CFG_CAL_C, 64'(plausible_c()));
      end
      write_reg(bpc_pkg::CFG_OSS, 64'($urandom_range(3)));
      for (int i = 0; i < 200; i++) begin
        if ($urandom_range(3) == 0) begin
          ut = 16'($urandom);
          up = 24'($urandom);
        end else begin
          ut = 16'(20000 + $urandom_range(15000));
          up = 24'(24'h400000 + $urandom_range(24'h300000));
        end
        // The first part of each phase runs without any gaps.
        send_reading(ut, up, i >= 60);
      end
      drain();
    end

    if (fail_count == 0)
      $display("baro_pressure_temp_compensation test passed");
    else
      $display("baro_pressure_temp_compensation test failed");
    $finish;
  end
endmodule

@@ files.f @@
src/bpc_pkg.sv
src/bpc_udiv_pipe.sv
src/bpc_temp_pre.sv
src/bpc_press_front.sv
src/bpc_press_back.sv
src/baro_pressure_temp_compensation.sv
tb/baro_comp_checker.sv
tb/testbench.sv
